// ----- rtl/lcbs_pkg.sv -----
// Shared types and constants for the line colour blob segmenter.
package lcbs_pkg;

  // Zone geometry
  localparam int unsigned MAX_ZONE_PIXELS = 256;
  localparam int unsigned PIX_IDX_W       = 9;

  // Significance fraction num/den, both below 2^21
  localparam int unsigned NUM_W = 21;
  localparam int unsigned DEN_W = 21;
  localparam int unsigned SIG_W = 16;
  localparam int unsigned SAT_MUL   = 5355;   // 7 * 765
  localparam int unsigned LUM_FULL  = 765;
  localparam int unsigned LUM_MUL   = 3;
  localparam int unsigned DEN_MUL   = 7650;
  localparam int unsigned BLACK_NUM = 3;
  localparam int unsigned BLACK_DEN = 10;
  localparam int unsigned THR_MUL   = 10;

  // Divider step counts
  localparam int unsigned SIG_STEPS  = 16;
  localparam int unsigned MEAN_STEPS = 8;

  // Register map (word index)
  localparam logic [1:0] REG_SIM_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_PIX   = 2'd1;
  localparam logic [1:0] REG_MAX_BLOBS = 2'd2;

  localparam logic [17:0] SIM_LIMIT_RST = 18'd900;
  localparam logic [8:0]  MIN_PIX_RST   = 9'd3;
  localparam logic [6:0]  MAX_BLOBS_RST = 7'd8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic        blob_valid;
    logic [7:0]  blob_start;
    logic [8:0]  blob_count;
    logic [7:0]  mean_red;
    logic [7:0]  mean_green;
    logic [7:0]  mean_blue;
    logic [15:0] blob_significance;
    logic        zone_done;
  } res_t;

  typedef struct packed {
    logic [17:0] similarity_limit;
    logic [8:0]  min_blob_pixels;
    logic [6:0]  max_blobs;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_SIG,
    ST_POST,
    ST_OUT,
    ST_FINAL,
    ST_MDIV,
    ST_BUILD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic decide;
    logic sig_step;
    logic mean_step;
    logic post;
    logic zone_end;
    logic build;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close1;
    logic last;
    logic final_emit;
  } sts_t;

endpackage

// ----- rtl/lcbs_regs.sv -----
// APB-style configuration registers.
module lcbs_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lcbs_pkg::cfg_t    cfg
);

  lcbs_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.similarity_limit <= lcbs_pkg::SIM_LIMIT_RST;
      cfg_r.min_blob_pixels  <= lcbs_pkg::MIN_PIX_RST;
      cfg_r.max_blobs        <= lcbs_pkg::MAX_BLOBS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        lcbs_pkg::REG_SIM_LIMIT: cfg_r.similarity_limit <= pwdata[17:0];
        lcbs_pkg::REG_MIN_PIX:   cfg_r.min_blob_pixels  <= pwdata[8:0];
        lcbs_pkg::REG_MAX_BLOBS: cfg_r.max_blobs        <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      lcbs_pkg::REG_SIM_LIMIT: prdata = {14'd0, cfg_r.similarity_limit};
      lcbs_pkg::REG_MIN_PIX:   prdata = {23'd0, cfg_r.min_blob_pixels};
      lcbs_pkg::REG_MAX_BLOBS: prdata = {25'd0, cfg_r.max_blobs};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/lcbs_ctrl.sv -----
// Sequencing state machine: one pixel at a time through calc, decide, divide, emit.
module lcbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lcbs_pkg::sts_t  sts,
  output lcbs_pkg::cmd_t  cmd
);

  lcbs_pkg::state_t state_r, state_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             go_final_r, go_final_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lcbs_pkg::ST_IDLE;
      cnt_r      <= 4'd0;
      go_final_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      go_final_r <= go_final_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    go_final_nxt = go_final_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      lcbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lcbs_pkg::ST_CALC;
        end
      end
      lcbs_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = lcbs_pkg::ST_DECIDE;
      end
      lcbs_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        cnt_nxt    = 4'd0;
        state_nxt  = lcbs_pkg::ST_SIG;
      end
      lcbs_pkg::ST_SIG: begin
        cmd.sig_step  = 1'b1;
        cmd.mean_step = (cnt_r < 4'(lcbs_pkg::MEAN_STEPS));
        cnt_nxt       = cnt_r + 4'd1;
        if (cnt_r == 4'(lcbs_pkg::SIG_STEPS - 1)) state_nxt = lcbs_pkg::ST_POST;
      end
      lcbs_pkg::ST_POST: begin
        cmd.post = 1'b1;
        if (sts.close1) begin
          go_final_nxt = sts.last;
          state_nxt    = lcbs_pkg::ST_OUT;
        end else if (sts.last) begin
          state_nxt = lcbs_pkg::ST_FINAL;
        end else begin
          state_nxt = lcbs_pkg::ST_IDLE;
        end
      end
      lcbs_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          go_final_nxt = 1'b0;
          state_nxt    = go_final_r ? lcbs_pkg::ST_FINAL : lcbs_pkg::ST_IDLE;
        end
      end
      lcbs_pkg::ST_FINAL: begin
        cmd.zone_end = 1'b1;
        cnt_nxt      = 4'd0;
        if (sts.final_emit)  state_nxt = lcbs_pkg::ST_MDIV;
        else if (sts.close1) state_nxt = lcbs_pkg::ST_IDLE;
        else                 state_nxt = lcbs_pkg::ST_OUT;   // bare zone-done marker
      end
      lcbs_pkg::ST_MDIV: begin
        cmd.mean_step = 1'b1;
        cnt_nxt       = cnt_r + 4'd1;
        if (cnt_r == 4'(lcbs_pkg::MEAN_STEPS - 1)) state_nxt = lcbs_pkg::ST_BUILD;
      end
      lcbs_pkg::ST_BUILD: begin
        cmd.build = 1'b1;
        state_nxt = lcbs_pkg::ST_OUT;
      end
      default: state_nxt = lcbs_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/lcbs_dp.sv -----
// Datapath: significance fraction, run state, serial dividers, result register.
module lcbs_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  lcbs_pkg::cmd_t  cmd,
  output lcbs_pkg::sts_t  sts,
  input  lcbs_pkg::cfg_t  cfg,
  input  lcbs_pkg::pix_t  in_data,
  output lcbs_pkg::res_t  out_data
);

  // pixel and per-pixel terms
  lcbs_pkg::pix_t                  pix_r;
  logic [lcbs_pkg::NUM_W-1:0]      num_r;
  logic [lcbs_pkg::DEN_W-1:0]      den_r;
  logic [17:0]                     dist_r;

  // run state
  logic [lcbs_pkg::PIX_IDX_W-1:0]  pix_idx_r;
  logic                            in_blob_r;
  logic [7:0]                      prev_red_r, prev_green_r, prev_blue_r;
  logic [7:0]                      run_start_r;
  logic [8:0]                      run_count_r;
  logic [15:0]                     sum_red_r, sum_green_r, sum_blue_r;
  logic [15:0]                     start_sig_r;
  logic [6:0]                      blobs_r;
  logic                            close1_r;
  logic                            started_r;

  // emission snapshot and dividers
  logic [7:0]                      em_start_r;
  logic [8:0]                      em_count_r;
  logic [15:0]                     em_sig_r;
  logic [lcbs_pkg::NUM_W:0]        srem_r;
  logic [15:0]                     sq_r;
  logic [7:0]                      mq_r   [3];
  logic [9:0]                      mrem_r [3];
  lcbs_pkg::res_t                  out_r;

  // combinational terms
  logic [7:0]                      mx, mn;
  logic [9:0]                      lum;
  logic [lcbs_pkg::NUM_W-1:0]      num_c;
  logic [lcbs_pkg::DEN_W-1:0]      den_c;
  logic signed [17:0]              dr, dg, db;
  logic [17:0]                     dist_c;
  logic [24:0]                     num10;
  logic                            sig_ok, extend, close_emit, start;
  logic [6:0]                      blobs_after;
  logic [lcbs_pkg::NUM_W:0]        st;
  logic [15:0]                     sums_snap [3];
  logic                            final_emit;

  assign out_data = out_r;

  // max, min and the exact significance fraction
  always_comb begin
    mx = pix_r.red;
    mn = pix_r.red;
    if (pix_r.green > mx) mx = pix_r.green;
    if (pix_r.blue  > mx) mx = pix_r.blue;
    if (pix_r.green < mn) mn = pix_r.green;
    if (pix_r.blue  < mn) mn = pix_r.blue;
    lum = 10'(lcbs_pkg::LUM_FULL) - (10'(pix_r.red) + 10'(pix_r.green) + 10'(pix_r.blue));
    if (mx == 8'd0) begin
      num_c = lcbs_pkg::NUM_W'(lcbs_pkg::BLACK_NUM);
      den_c = lcbs_pkg::DEN_W'(lcbs_pkg::BLACK_DEN);
    end else begin
      num_c = lcbs_pkg::NUM_W'(21'(mx - mn) * 21'(lcbs_pkg::SAT_MUL))
            + lcbs_pkg::NUM_W'(21'(mx) * 21'(lum) * 21'(lcbs_pkg::LUM_MUL));
      den_c = lcbs_pkg::DEN_W'(21'(mx) * 21'(lcbs_pkg::DEN_MUL));
    end
  end

  // squared distance to the previous pixel
  always_comb begin
    dr     = 18'(signed'({1'b0, pix_r.red})   - signed'({1'b0, prev_red_r}));
    dg     = 18'(signed'({1'b0, pix_r.green}) - signed'({1'b0, prev_green_r}));
    db     = 18'(signed'({1'b0, pix_r.blue})  - signed'({1'b0, prev_blue_r}));
    dist_c = 18'($unsigned(dr * dr)) + 18'($unsigned(dg * dg)) + 18'($unsigned(db * db));
  end

  // run decisions for the current pixel
  always_comb begin
    num10       = 25'(num_r) * 25'(lcbs_pkg::THR_MUL);
    sig_ok      = (pix_idx_r < lcbs_pkg::PIX_IDX_W'(lcbs_pkg::MAX_ZONE_PIXELS))
                  && (num10 > 25'(den_r));
    extend      = in_blob_r && sig_ok && (dist_r < cfg.similarity_limit);
    close_emit  = in_blob_r && !extend && (run_count_r >= cfg.min_blob_pixels);
    blobs_after = blobs_r + 7'(close_emit);
    start       = !extend && sig_ok && (blobs_after < cfg.max_blobs);
    final_emit  = in_blob_r && (run_count_r >= cfg.min_blob_pixels);
    st          = {srem_r[lcbs_pkg::NUM_W-1:0], 1'b0};
  end

  assign sts.close1     = close1_r;
  assign sts.last       = pix_r.last_pixel;
  assign sts.final_emit = final_emit;

  // pixel capture and per-pixel terms
  always_ff @(posedge clk) begin
    if (cmd.load) pix_r <= in_data;
    if (cmd.calc) begin
      num_r  <= num_c;
      den_r  <= den_c;
      dist_r <= dist_c;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_idx_r    <= '0;
      in_blob_r    <= 1'b0;
      prev_red_r   <= '0;
      prev_green_r <= '0;
      prev_blue_r  <= '0;
      run_start_r  <= '0;
      run_count_r  <= '0;
      sum_red_r    <= '0;
      sum_green_r  <= '0;
      sum_blue_r   <= '0;
      start_sig_r  <= '0;
      blobs_r      <= '0;
      close1_r     <= 1'b0;
      started_r    <= 1'b0;
    end else if (cmd.decide) begin
      close1_r     <= close_emit;
      started_r    <= start;
      blobs_r      <= blobs_after;
      prev_red_r   <= pix_r.red;
      prev_green_r <= pix_r.green;
      prev_blue_r  <= pix_r.blue;
      if (!pix_r.last_pixel
          && pix_idx_r < lcbs_pkg::PIX_IDX_W'(lcbs_pkg::MAX_ZONE_PIXELS)) begin
        pix_idx_r <= pix_idx_r + 1'b1;
      end
      if (extend) begin
        run_count_r <= run_count_r + 9'd1;
        sum_red_r   <= sum_red_r   + 16'(pix_r.red);
        sum_green_r <= sum_green_r + 16'(pix_r.green);
        sum_blue_r  <= sum_blue_r  + 16'(pix_r.blue);
      end else if (start) begin
        in_blob_r   <= 1'b1;
        run_start_r <= pix_idx_r[7:0];
        run_count_r <= 9'd1;
        sum_red_r   <= 16'(pix_r.red);
        sum_green_r <= 16'(pix_r.green);
        sum_blue_r  <= 16'(pix_r.blue);
      end else begin
        in_blob_r <= 1'b0;
      end
    end else if (cmd.post) begin
      if (started_r) start_sig_r <= sq_r;
    end else if (cmd.zone_end) begin
      pix_idx_r <= '0;
      in_blob_r <= 1'b0;
      blobs_r   <= '0;
    end
  end

  // snapshot of the blob being emitted
  always_comb begin
    sums_snap[0] = sum_red_r;
    sums_snap[1] = sum_green_r;
    sums_snap[2] = sum_blue_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.decide || cmd.zone_end) begin
      em_start_r <= run_start_r;
      em_count_r <= run_count_r;
      em_sig_r   <= start_sig_r;
    end
  end

  // significance divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      srem_r <= {1'b0, num_r};
      sq_r   <= '0;
    end else if (cmd.sig_step) begin
      if (st >= {1'b0, den_r}) begin
        srem_r <= st - {1'b0, den_r};
        sq_r   <= {sq_r[14:0], 1'b1};
      end else begin
        srem_r <= st;
        sq_r   <= {sq_r[14:0], 1'b0};
      end
    end
  end

  // three mean dividers; quotient below 256 so start from the top byte
  for (genvar c = 0; c < 3; c++) begin : g_mean
    logic [9:0] mt;
    assign mt = {mrem_r[c][8:0], mq_r[c][7]};
    always_ff @(posedge clk) begin
      if (cmd.decide || cmd.zone_end) begin
        mrem_r[c] <= {2'b00, sums_snap[c][15:8]};
        mq_r[c]   <= sums_snap[c][7:0];
      end else if (cmd.mean_step) begin
        if (mt >= {1'b0, em_count_r}) begin
          mrem_r[c] <= mt - {1'b0, em_count_r};
          mq_r[c]   <= {mq_r[c][6:0], 1'b1};
        end else begin
          mrem_r[c] <= mt;
          mq_r[c]   <= {mq_r[c][6:0], 1'b0};
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((cmd.post && close1_r) || cmd.build) begin
      out_r.blob_valid        <= 1'b1;
      out_r.blob_start        <= em_start_r;
      out_r.blob_count        <= em_count_r;
      out_r.mean_red          <= mq_r[0];
      out_r.mean_green        <= mq_r[1];
      out_r.mean_blue         <= mq_r[2];
      out_r.blob_significance <= em_sig_r;
      out_r.zone_done         <= cmd.build || (pix_r.last_pixel && !final_emit);
    end else if (cmd.zone_end && !final_emit && !close1_r) begin
      out_r           <= '0;
      out_r.zone_done <= 1'b1;
    end
  end

endmodule

// ----- rtl/line_color_blob_segmenter.sv -----
// Line colour blob segmenter: top level.
// Usage:
//   in_valid/in_ready/in_data carry one RGB pixel a beat with a last-pixel flag.
//   out_valid/out_ready/out_data carry one result a beat: a blob (start, count,
//   floor mean colour, start significance in Q0.16) or a bare zone-done marker.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready: registers similarity_limit
//   (0x0), min_blob_pixels (0x4), max_blobs (0x8); write only while idle.
// Timing:
//   One pixel at a time. A pixel that emits nothing passes calc, decide, the
//   bit-serial significance divider and post before in_ready returns; blob
//   means come from three bit-serial dividers run alongside it. A closing
//   blob adds one result beat. The last pixel of a zone adds another mean
//   division when its own blob closes, plus one result beat, or a marker beat.
// Reset (rst_n low, synchronous) clears the zone state and loads register
// defaults. While out_ready is low the result is held and no pixel is taken.
module line_color_blob_segmenter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lcbs_pkg::pix_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lcbs_pkg::res_t   out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  lcbs_pkg::cfg_t cfg;
  lcbs_pkg::cmd_t cmd;
  lcbs_pkg::sts_t sts;

  lcbs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcbs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- rtl/lcbs_checker.sv -----
// Port-level checks for the segmenter, bound to the top level.
module lcbs_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input lcbs_pkg::pix_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input lcbs_pkg::res_t  out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // pixels are not taken while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // pixels are never taken back to back
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken back to back");

  // a marker always closes a zone
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.blob_valid |-> out_data.zone_done)
    else $error("bare result without zone done");

  // an emitted blob is never empty
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.blob_valid |-> out_data.blob_count != 9'd0)
    else $error("empty blob emitted");

endmodule

bind line_color_blob_segmenter lcbs_checker u_lcbs_checker (.*);
